[design/mafxy_pkg.sv]
// ----------------------------------------------------------------------------
// mafxy_pkg
// Shared types, widths and constants of the magnetic angle unit.
// ----------------------------------------------------------------------------
package mafxy_pkg;

  // Iteration count limits
  localparam int MAX_STAGES     = 24;
  localparam int CORDIC_STAGES  = 16;

  // Datapath widths: x/y carry |X|,|Y| in Q16 plus CORDIC growth, z is Q16 degrees
  localparam int XW = 31;
  localparam int ZW = 25;
  localparam int AW = 22;

  // Octant clamp bounds in Q16 degrees
  localparam logic signed [ZW-1:0] PHI_LO_LOW  = ZW'(1);
  localparam logic signed [ZW-1:0] PHI_HI_LOW  = ZW'(45 * 65536 - 1);
  localparam logic signed [ZW-1:0] PHI_LO_HIGH = ZW'(45 * 65536 + 1);
  localparam logic signed [ZW-1:0] PHI_HI_HIGH = ZW'(90 * 65536 - 1);

  // Offsets of the quadrant fold in Q16 degrees
  localparam logic [ZW-1:0] OFS_180 = ZW'(180 * 65536);
  localparam logic [ZW-1:0] OFS_360 = ZW'(360 * 65536);

  // Exact-case angles
  localparam logic [8:0] ANG_45  = 9'd45;
  localparam logic [8:0] ANG_90  = 9'd90;
  localparam logic [8:0] ANG_135 = 9'd135;
  localparam logic [8:0] ANG_180 = 9'd180;
  localparam logic [8:0] ANG_225 = 9'd225;
  localparam logic [8:0] ANG_270 = 9'd270;
  localparam logic [8:0] ANG_315 = 9'd315;
  localparam logic [8:0] ANG_360 = 9'd360;

  // Per-item control travelling with the data
  typedef struct packed {
    logic       exact;        // axis or diagonal, angle known up front
    logic [8:0] exact_angle;
    logic       x_neg;
    logic       y_pos;
    logic       y_lt_x;       // |Y| < |X| selects the lower octant
  } ctl_t;

  typedef struct packed {
    logic [11:0]            fx;
    logic [11:0]            fy;
    ctl_t                   ctl;
    logic signed [XW-1:0]   cx;
    logic signed [XW-1:0]   cy;
    logic signed [ZW-1:0]   cz;
  } stage_t;

  // round(atan(2^-i) in degrees * 2^16)
  function automatic logic [AW-1:0] atan_q16(input int unsigned i);
    logic [AW-1:0] a;
    unique case (i)
      0:       a = AW'(2949120);
      1:       a = AW'(1740967);
      2:       a = AW'(919879);
      3:       a = AW'(466945);
      4:       a = AW'(234379);
      5:       a = AW'(117304);
      6:       a = AW'(58666);
      7:       a = AW'(29335);
      8:       a = AW'(14668);
      9:       a = AW'(7334);
      10:      a = AW'(3667);
      11:      a = AW'(1833);
      12:      a = AW'(917);
      13:      a = AW'(458);
      14:      a = AW'(229);
      15:      a = AW'(115);
      16:      a = AW'(57);
      17:      a = AW'(29);
      18:      a = AW'(14);
      19:      a = AW'(7);
      20:      a = AW'(4);
      21:      a = AW'(2);
      22:      a = AW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[design/mafxy_if.sv]
// ----------------------------------------------------------------------------
// mafxy_if
// Valid/ready channels of the magnetic angle unit: raw sensor beat in,
// field components and angle out.
// ----------------------------------------------------------------------------
interface mafxy_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_high_byte;
  logic [7:0] y_high_byte;
  logic [7:0] low_nibbles_byte;

  modport source (output valid, x_high_byte, y_high_byte, low_nibbles_byte,
                  input ready);
  modport sink   (input valid, x_high_byte, y_high_byte, low_nibbles_byte,
                  output ready);
endinterface

interface mafxy_out_if;
  logic              valid;
  logic              ready;
  logic signed [11:0] field_x;
  logic signed [11:0] field_y;
  logic [8:0]        angle_degrees;

  modport source (output valid, field_x, field_y, angle_degrees, input ready);
  modport sink   (input valid, field_x, field_y, angle_degrees, output ready);
endinterface

[design/mafxy_unpack.sv]
// ----------------------------------------------------------------------------
// mafxy_unpack
// Input stage: rebuilds X/Y, takes magnitudes, decides axes and diagonals
// and loads the CORDIC start vector.
// ----------------------------------------------------------------------------
module mafxy_unpack (
  input  logic                clk,
  input  logic                rst_n,
  mafxy_in_if.sink            in_ch,
  output logic                v_o,
  output mafxy_pkg::stage_t   d_o,
  input  logic                rdy_i
);

  logic              v_r;
  mafxy_pkg::stage_t d_r;
  mafxy_pkg::stage_t d_nxt;
  logic [11:0]       xr;
  logic [11:0]       yr;
  logic [11:0]       ax;
  logic [11:0]       ay;
  logic              x_zero;
  logic              y_zero;
  logic              y_pos;

  assign in_ch.ready = !v_r || rdy_i;

  // Rebuild the 12-bit components and their magnitudes
  always_comb begin
    xr     = {in_ch.x_high_byte, in_ch.low_nibbles_byte[7:4]};
    yr     = {in_ch.y_high_byte, in_ch.low_nibbles_byte[3:0]};
    ax     = xr[11] ? (~xr + 12'd1) : xr;
    ay     = yr[11] ? (~yr + 12'd1) : yr;
    x_zero = (xr == 12'd0);
    y_zero = (yr == 12'd0);
    y_pos  = !yr[11] && !y_zero;
  end

  // Exact cases and CORDIC start vector
  always_comb begin
    d_nxt.fx         = xr;
    d_nxt.fy         = yr;
    d_nxt.ctl.x_neg  = xr[11];
    d_nxt.ctl.y_pos  = y_pos;
    d_nxt.ctl.y_lt_x = (ay < ax);
    d_nxt.ctl.exact  = y_zero || x_zero || (ax == ay);
    priority if (y_zero) begin
      d_nxt.ctl.exact_angle = xr[11] ? mafxy_pkg::ANG_360 : mafxy_pkg::ANG_180;
    end else if (x_zero) begin
      d_nxt.ctl.exact_angle = y_pos ? mafxy_pkg::ANG_270 : mafxy_pkg::ANG_90;
    end else if (!xr[11]) begin
      d_nxt.ctl.exact_angle = y_pos ? mafxy_pkg::ANG_225 : mafxy_pkg::ANG_135;
    end else begin
      d_nxt.ctl.exact_angle = y_pos ? mafxy_pkg::ANG_315 : mafxy_pkg::ANG_45;
    end
    d_nxt.cx = {3'b000, ax, 16'h0000};
    d_nxt.cy = {3'b000, ay, 16'h0000};
    d_nxt.cz = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

[design/mafxy_cordic_stage.sv]
// ----------------------------------------------------------------------------
// mafxy_cordic_stage
// One vectoring iteration: rotate toward y = 0 by atan(2^-SHIFT) and
// accumulate the angle. Holds its beat while downstream stalls.
// ----------------------------------------------------------------------------
module mafxy_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  mafxy_pkg::stage_t   d_i,
  output logic                rdy_o,
  output logic                v_o,
  output mafxy_pkg::stage_t   d_o,
  input  logic                rdy_i
);

  localparam logic [mafxy_pkg::AW-1:0] ANGLE = mafxy_pkg::atan_q16(SHIFT);

  logic                               v_r;
  mafxy_pkg::stage_t                  d_r;
  mafxy_pkg::stage_t                  d_nxt;
  logic signed [mafxy_pkg::XW-1:0]    dx;
  logic signed [mafxy_pkg::XW-1:0]    dy;
  logic signed [mafxy_pkg::ZW-1:0]    da;

  assign rdy_o = !v_r || rdy_i;

  // Micro-rotation, flooring shifts
  always_comb begin
    dx    = d_i.cy >>> SHIFT;
    dy    = d_i.cx >>> SHIFT;
    da    = $signed({{(mafxy_pkg::ZW - mafxy_pkg::AW){1'b0}}, ANGLE});
    d_nxt = d_i;
    if (d_i.cy > 0) begin
      d_nxt.cx = d_i.cx + dx;
      d_nxt.cy = d_i.cy - dy;
      d_nxt.cz = d_i.cz + da;
    end else begin
      d_nxt.cx = d_i.cx - dx;
      d_nxt.cy = d_i.cy + dy;
      d_nxt.cz = d_i.cz - da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

[design/mafxy_finish.sv]
// ----------------------------------------------------------------------------
// mafxy_finish
// Output stage: clamps the CORDIC angle into its octant, folds it into the
// quadrant, picks exact cases and holds the result beat.
// ----------------------------------------------------------------------------
module mafxy_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  mafxy_pkg::stage_t   d_i,
  output logic                rdy_o,
  mafxy_out_if.source         out_ch
);

  logic                             v_r;
  logic [11:0]                      fx_r;
  logic [11:0]                      fy_r;
  logic [8:0]                       ang_r;
  logic signed [mafxy_pkg::ZW-1:0]  lo;
  logic signed [mafxy_pkg::ZW-1:0]  hi;
  logic signed [mafxy_pkg::ZW-1:0]  phi_s;
  logic [mafxy_pkg::ZW-1:0]         phi;
  logic [mafxy_pkg::ZW-1:0]         a;
  logic [8:0]                       ang_nxt;

  assign rdy_o = !v_r || out_ch.ready;

  // Octant clamp
  always_comb begin
    lo = d_i.ctl.y_lt_x ? mafxy_pkg::PHI_LO_LOW : mafxy_pkg::PHI_LO_HIGH;
    hi = d_i.ctl.y_lt_x ? mafxy_pkg::PHI_HI_LOW : mafxy_pkg::PHI_HI_HIGH;
    priority if (d_i.cz < lo) begin
      phi_s = lo;
    end else if (d_i.cz > hi) begin
      phi_s = hi;
    end else begin
      phi_s = d_i.cz;
    end
    phi = $unsigned(phi_s);
  end

  // Quadrant fold, then whole degrees
  always_comb begin
    unique case ({d_i.ctl.x_neg, d_i.ctl.y_pos})
      2'b01:   a = mafxy_pkg::OFS_180 + phi;
      2'b00:   a = mafxy_pkg::OFS_180 - phi;
      2'b11:   a = mafxy_pkg::OFS_360 - phi;
      default: a = phi;
    endcase
    ang_nxt = d_i.ctl.exact ? d_i.ctl.exact_angle : a[24:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      fx_r  <= d_i.fx;
      fy_r  <= d_i.fy;
      ang_r <= ang_nxt;
    end
  end

  assign out_ch.valid         = v_r;
  assign out_ch.field_x       = $signed(fx_r);
  assign out_ch.field_y       = $signed(fy_r);
  assign out_ch.angle_degrees = ang_r;

endmodule

[design/magnetic_angle_from_xy_unit.sv]
// ----------------------------------------------------------------------------
// magnetic_angle_from_xy_unit
// Field angle from raw X/Y sensor bytes by a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat carries x_high_byte, y_high_byte and low_nibbles_byte.
//   out_ch : one beat per input beat, in order: field_x, field_y (signed
//            12-bit) and angle_degrees = floor(atan2(Y,X) in degrees + 180).
//   Both channels move a beat when valid and ready are high at a clock edge.
// Stages: CORDIC_STAGES + 2 register stages (one unpack register, one per
//   CORDIC iteration, one output register; iterations capped at 24).
//   A beat passes the unpack register, each CORDIC register and the output
//   register in that order before out_ch.valid shows it.
// Throughput: one beat per cycle unless out_ch stalls; a stage per iteration.
// Stall: every stage holds its beat while its successor is full and stalled;
//   empty stages in front of it keep filling, so the input is still ready
//   until the whole pipeline is full. Nothing is dropped or repeated.
// Reset: rst_n (synchronous, active low) empties all stages; payload
//   registers are not cleared. There is no configuration.
// ----------------------------------------------------------------------------
module magnetic_angle_from_xy_unit #(
  parameter int CORDIC_STAGES = mafxy_pkg::CORDIC_STAGES
) (
  input  logic         clk,
  input  logic         rst_n,
  mafxy_in_if.sink     in_ch,
  mafxy_out_if.source  out_ch
);

  localparam int N = (CORDIC_STAGES > mafxy_pkg::MAX_STAGES) ?
                     mafxy_pkg::MAX_STAGES : CORDIC_STAGES;

  logic              v   [0:N];
  logic              rdy [0:N];
  mafxy_pkg::stage_t d   [0:N];

  // Unpack and exact-case stage
  mafxy_unpack u_unpack (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .v_o   (v[0]),
    .d_o   (d[0]),
    .rdy_i (rdy[0])
  );

  // CORDIC iterations, one register stage each
  for (genvar i = 0; i < N; i++) begin : g_stage
    mafxy_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (v[i]),
      .d_i   (d[i]),
      .rdy_o (rdy[i]),
      .v_o   (v[i+1]),
      .d_o   (d[i+1]),
      .rdy_i (rdy[i+1])
    );
  end

  // Clamp, quadrant fold and output register
  mafxy_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v[N]),
    .d_i    (d[N]),
    .rdy_o  (rdy[N]),
    .out_ch (out_ch)
  );

  // Checks
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.angle_degrees <= 9'd360)
    else $error("angle out of range");

  a_x_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.field_y == 12'sd0) |->
      (out_ch.angle_degrees == 9'd180 || out_ch.angle_degrees == 9'd360))
    else $error("X axis angle wrong");

  a_y_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.field_x == 12'sd0 && out_ch.field_y != 12'sd0) |->
      (out_ch.angle_degrees == 9'd90 || out_ch.angle_degrees == 9'd270))
    else $error("Y axis angle wrong");

  a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v[0] |-> in_ch.ready)
    else $error("input stalled with empty front stage");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for magnetic_angle_from_xy_unit. Raw sensor beats go in
// through a valid/ready channel with random gaps. A scoreboard rebuilds X/Y
// and runs its own CORDIC to predict each angle, then checks every output
// beat in order. Phases cover directed corners, random readings, a long
// output stall that backs the pipeline up, and full-rate streaming.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = mafxy_pkg::CORDIC_STAGES + 12;

  typedef struct packed {
    logic signed [11:0] fx;
    logic signed [11:0] fy;
    logic [8:0]         ang;
  } reading_t;

  // Predicts field components and angle; holds results still owed by the DUT
  class angle_scoreboard;
    reading_t awaited_readings[$];
    int       errors;
    longint   atan_tab[mafxy_pkg::MAX_STAGES] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
    };

    function new();
      errors = 0;
    endfunction

    // floor(atan2(y,x) in degrees + 180)
    function logic [8:0] predict_angle(int x, int y);
      int     ax, ay, stages;
      longint cx, cy, cz, dx, dy, lo, hi, a;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      // axes and diagonals are exact
      if (y == 0) return (x < 0) ? mafxy_pkg::ANG_360 : mafxy_pkg::ANG_180;
      if (x == 0) return (y > 0) ? mafxy_pkg::ANG_270 : mafxy_pkg::ANG_90;
      if (ax == ay) begin
        if (x > 0) return (y > 0) ? mafxy_pkg::ANG_225 : mafxy_pkg::ANG_135;
        return (y > 0) ? mafxy_pkg::ANG_315 : mafxy_pkg::ANG_45;
      end
      // vectoring CORDIC on |X|,|Y| in Q16
      stages = (mafxy_pkg::CORDIC_STAGES > mafxy_pkg::MAX_STAGES) ?
               mafxy_pkg::MAX_STAGES : mafxy_pkg::CORDIC_STAGES;
      cx = longint'(ax) <<< 16;
      cy = longint'(ay) <<< 16;
      cz = 0;
      for (int i = 0; i < stages; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx += dx;
          cy -= dy;
          cz += atan_tab[i];
        end else begin
          cx -= dx;
          cy += dy;
          cz -= atan_tab[i];
        end
      end
      // keep phi strictly inside its octant
      if (ay < ax) begin
        lo = 1;
        hi = 45 * 65536 - 1;
      end else begin
        lo = 45 * 65536 + 1;
        hi = 90 * 65536 - 1;
      end
      if (cz < lo) cz = lo;
      if (cz > hi) cz = hi;
      // quadrant fold
      if (x > 0) a = (y > 0) ? 180 * 65536 + cz : 180 * 65536 - cz;
      else       a = (y > 0) ? 360 * 65536 - cz : cz;
      return 9'(a >>> 16);
    endfunction

    function void note_reading(logic [7:0] xh, logic [7:0] yh, logic [7:0] ln);
      reading_t r;
      r.fx  = {xh, ln[7:4]};
      r.fy  = {yh, ln[3:0]};
      r.ang = predict_angle(int'(r.fx), int'(r.fy));
      awaited_readings.push_back(r);
    endfunction

    function void check_result(logic signed [11:0] fx, logic signed [11:0] fy,
                               logic [8:0] ang);
      reading_t e;
      if (awaited_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat fx=%0d fy=%0d angle=%0d",
                 $time, fx, fy, ang);
        return;
      end
      e = awaited_readings.pop_front();
      if (fx !== e.fx) begin
        errors++;
        $display("%0t: field_x expected %0d got %0d", $time, e.fx, fx);
      end
      if (fy !== e.fy) begin
        errors++;
        $display("%0t: field_y expected %0d got %0d", $time, e.fy, fy);
      end
      if (ang !== e.ang) begin
        errors++;
        $display("%0t: angle_degrees expected %0d got %0d (x=%0d y=%0d)",
                 $time, e.ang, ang, e.fx, e.fy);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   tx_idle_en;
  bit   rx_idle_en;
  bit   hold_req;

  angle_scoreboard sb = new();

  mafxy_in_if  in_ch();
  mafxy_out_if out_ch();

  magnetic_angle_from_xy_unit #(
    .CORDIC_STAGES(mafxy_pkg::CORDIC_STAGES)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Input and output beat monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_reading(in_ch.x_high_byte, in_ch.y_high_byte, in_ch.low_nibbles_byte);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.field_x, out_ch.field_y, out_ch.angle_degrees);
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Output side: random stalls, plus one long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    hold_req     = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = rx_idle_en ? pick_gap() : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one beat and wait for it to be taken
  task automatic send_bytes(input logic [7:0] xh, input logic [7:0] yh,
                            input logic [7:0] ln);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.x_high_byte      <= xh;
    in_ch.y_high_byte      <= yh;
    in_ch.low_nibbles_byte <= ln;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_xy(input int x, input int y);
    logic [11:0] xv, yv;
    xv = x[11:0];
    yv = y[11:0];
    send_bytes(xv[11:4], yv[11:4], {xv[3:0], yv[3:0]});
  endtask

  // Mostly uniform bytes, the rest axes, diagonals and near-diagonals
  task automatic send_random_reading();
    int r, m, sx, sy;
    r  = int'($urandom_range(0, 99));
    m  = int'($urandom_range(2, 2047));
    sx = $urandom_range(0, 1) ? -1 : 1;
    sy = $urandom_range(0, 1) ? -1 : 1;
    if (r < 70)
      send_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    else if (r < 80)
      send_xy(sx * m, sy * m);
    else if (r < 86)
      send_xy($urandom_range(0, 1) ? sx * m : 0, 0);
    else if (r < 90)
      send_xy(0, sy * m);
    else if ($urandom_range(0, 1))
      send_xy(sx * m, sy * (m - 1));
    else
      send_xy(sx * (m - 1), sy * m);
  endtask

  task automatic wait_all_results();
    while (sb.awaited_readings.size() != 0) @(posedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Main sequence
  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.x_high_byte      = '0;
    in_ch.y_high_byte      = '0;
    in_ch.low_nibbles_byte = '0;
    tx_idle_en             = 1'b1;
    rx_idle_en             = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both zero, axes, diagonals, extremes, near-diagonals
    send_xy(0, 0);
    send_xy(2047, 0);
    send_xy(-2048, 0);
    send_xy(0, 2047);
    send_xy(0, -2048);
    send_xy(1, 0);
    send_xy(-1, 0);
    send_xy(0, 1);
    send_xy(0, -1);
    send_xy(5, 5);
    send_xy(-5, 5);
    send_xy(-5, -5);
    send_xy(5, -5);
    send_xy(2047, 2047);
    send_xy(-2048, -2048);
    send_xy(-2048, 2047);
    send_xy(2047, -2048);
    send_xy(100, 99);
    send_xy(99, 100);
    send_xy(-100, -99);
    send_xy(2047, 1);
    send_xy(1, 2047);
    send_xy(-2047, -1);
    send_xy(3, -1000);
    end_burst();
    wait_all_results();

    // Random with idling on both sides
    repeat (400) send_random_reading();

    // Output held off while input keeps offering: pipeline fills and stalls
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (60) send_random_reading();
    end_burst();
    tx_idle_en = 1'b1;

    // Sender waits for every result before going on
    wait_all_results();

    // Full-rate stretch
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (300) send_random_reading();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    repeat (350) send_random_reading();
    end_burst();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
